[design/nvs_pkg.sv]
// ---------------------------------------------------------------------------
// nvs_pkg: shared types and codes of the nearest vertex search block
// Holds the field widths of the stream ports, the operation and status
// codes, and the tag that travels beside each point through the distance
// pipeline.
// ---------------------------------------------------------------------------
package nvs_pkg;

  localparam int unsigned IN_COORD_W = 14;
  localparam int unsigned IDX_OUT_W  = 10;
  localparam int unsigned DIST_OUT_W = 15;
  localparam int unsigned STAT_W     = 2;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 32;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic vld;
    logic last;
  } tag_t;

endpackage

[design/nearest_vertex_search.sv]
// ---------------------------------------------------------------------------
// nearest_vertex_search: point table with brute force nearest point lookup
// Stores 3-D points in a table memory and finds the stored point with the
// smallest floored Euclidean distance to a query point.
//
// Channel  Ports       tdata (low bit first)                  tuser
// in       in_t*       coord_x, coord_y, coord_z, zero pad    operation
// out      out_t*      point_index, nearest_distance, pad     status
//
// An add's result is loaded into the output register in the cycle the
// transaction is accepted. A query reads one stored point per cycle from
// the table memory into the distance pipelines; its result is loaded once
// the last root is out and the output register is free. Reset clears the
// point count but not the table memory. Input is taken only when no item
// is in progress and the output register is free.
// ---------------------------------------------------------------------------
module nearest_vertex_search #(
  parameter int unsigned MAX_POINTS = 1024,
  parameter int unsigned COORD_BITS = 14
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // coord_x[13:0], coord_y[27:14], coord_z[41:28], zero pad[47:42]
  input  logic [nvs_pkg::IN_DATA_W-1:0]  in_tdata,
  // operation[0]
  input  logic                           in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // point_index[9:0], nearest_distance[24:10], zero pad[31:25]
  output logic [nvs_pkg::OUT_DATA_W-1:0] out_tdata,
  // status[1:0]
  output logic [nvs_pkg::STAT_W-1:0]     out_tuser
);

  localparam int unsigned CB    = COORD_BITS;
  localparam int unsigned IDX_W = $clog2(MAX_POINTS);
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned PT_W  = 3 * CB;
  localparam int unsigned RAD_W = 2 * CB + 2;
  localparam int unsigned RW    = CB + 1;
  localparam int unsigned IW    = nvs_pkg::IDX_OUT_W;
  localparam int unsigned DW    = nvs_pkg::DIST_OUT_W;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SCAN  = 4'b0010,
    S_DRAIN = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]         count_r, count_nxt;
  logic [IDX_W-1:0]         addr_r, addr_nxt;
  logic [IDX_W-1:0]         res_idx_r, res_idx_nxt;
  logic                     best_vld_r, best_vld_nxt;
  logic [RW-1:0]            best_d_r, best_d_nxt;
  logic [IDX_W-1:0]         best_idx_r, best_idx_nxt;
  logic [PT_W-1:0]          query_r, query_nxt;
  nvs_pkg::tag_t            rd_tag_r, rd_tag_nxt;
  logic                     out_vld_r, out_vld_nxt;
  logic [IW-1:0]            out_idx_r, out_idx_nxt;
  logic [DW-1:0]            out_dist_r, out_dist_nxt;
  logic [nvs_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;

  logic                     in_acc;
  logic                     out_free;
  logic [PT_W-1:0]          in_point;
  logic                     mem_wr_en;
  logic                     mem_rd_en;
  logic [PT_W-1:0]          mem_rd_data;
  logic                     scan_last;
  nvs_pkg::tag_t            sq_tag;
  logic [RAD_W-1:0]         sum_sq;
  nvs_pkg::tag_t            rt_tag;
  logic [RW-1:0]            rt_root;
  logic [IDX_W+IW-1:0]      cnt_idx_ext;
  logic [IDX_W+IW-1:0]      best_idx_ext;
  logic [RW+DW-1:0]         best_d_ext;

  assign out_free  = !out_vld_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign in_acc    = in_tvalid && in_tready;

  assign in_point = {in_tdata[2*nvs_pkg::IN_COORD_W +: CB],
                     in_tdata[nvs_pkg::IN_COORD_W +: CB],
                     in_tdata[0 +: CB]};

  assign mem_wr_en = in_acc && (in_tuser == nvs_pkg::OP_ADD) &&
                     (count_r != CNT_W'(MAX_POINTS));
  assign mem_rd_en = (state_r == S_SCAN);
  assign scan_last = (CNT_W'(addr_r) + CNT_W'(1) == count_r);

  assign cnt_idx_ext  = {{IW{1'b0}}, count_r[IDX_W-1:0]};
  assign best_idx_ext = {{IW{1'b0}}, best_idx_r};
  assign best_d_ext   = {{DW{1'b0}}, best_d_r};

  nvs_point_mem #(
    .DEPTH  (MAX_POINTS),
    .DATA_W (PT_W)
  ) u_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (count_r[IDX_W-1:0]),
    .wr_data (in_point),
    .rd_en   (mem_rd_en),
    .rd_addr (addr_r),
    .rd_data (mem_rd_data)
  );

  nvs_sq_dist #(
    .COORD_BITS (CB)
  ) u_sq (
    .clk     (clk),
    .rst_n   (rst_n),
    .tag_in  (rd_tag_r),
    .point   (mem_rd_data),
    .query   (query_r),
    .tag_out (sq_tag),
    .sum_sq  (sum_sq)
  );

  nvs_isqrt #(
    .RAD_W (RAD_W)
  ) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .tag_in   (sq_tag),
    .radicand (sum_sq),
    .tag_out  (rt_tag),
    .root     (rt_root)
  );

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    addr_nxt     = addr_r;
    res_idx_nxt  = res_idx_r;
    best_vld_nxt = best_vld_r;
    best_d_nxt   = best_d_r;
    best_idx_nxt = best_idx_r;
    query_nxt    = query_r;
    rd_tag_nxt   = '0;
    out_vld_nxt  = out_vld_r && !out_tready;
    out_idx_nxt  = out_idx_r;
    out_dist_nxt = out_dist_r;
    out_stat_nxt = out_stat_r;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_tuser == nvs_pkg::OP_ADD) begin
            out_vld_nxt  = 1'b1;
            out_dist_nxt = '0;
            if (count_r == CNT_W'(MAX_POINTS)) begin
              out_idx_nxt  = '0;
              out_stat_nxt = nvs_pkg::STAT_FULL;
            end else begin
              out_idx_nxt  = cnt_idx_ext[IW-1:0];
              out_stat_nxt = nvs_pkg::STAT_OK;
              count_nxt    = count_r + CNT_W'(1);
            end
          end else if (count_r == '0) begin
            out_vld_nxt  = 1'b1;
            out_idx_nxt  = '0;
            out_dist_nxt = '0;
            out_stat_nxt = nvs_pkg::STAT_EMPTY;
          end else begin
            query_nxt    = in_point;
            addr_nxt     = '0;
            res_idx_nxt  = '0;
            best_vld_nxt = 1'b0;
            state_nxt    = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        rd_tag_nxt.vld  = 1'b1;
        rd_tag_nxt.last = scan_last;
        addr_nxt        = addr_r + IDX_W'(1);
        if (scan_last) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (rt_tag.vld && rt_tag.last) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_vld_nxt  = 1'b1;
          out_idx_nxt  = best_idx_ext[IW-1:0];
          out_dist_nxt = best_d_ext[DW-1:0];
          out_stat_nxt = nvs_pkg::STAT_OK;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (rt_tag.vld) begin
      res_idx_nxt = res_idx_r + IDX_W'(1);
      if (!best_vld_r || (rt_root < best_d_r)) begin
        best_vld_nxt = 1'b1;
        best_d_nxt   = rt_root;
        best_idx_nxt = res_idx_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      rd_tag_r   <= '0;
      out_vld_r  <= 1'b0;
      best_vld_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      rd_tag_r   <= rd_tag_nxt;
      out_vld_r  <= out_vld_nxt;
      best_vld_r <= best_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    res_idx_r  <= res_idx_nxt;
    best_d_r   <= best_d_nxt;
    best_idx_r <= best_idx_nxt;
    query_r    <= query_nxt;
    out_idx_r  <= out_idx_nxt;
    out_dist_r <= out_dist_nxt;
    out_stat_r <= out_stat_nxt;
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {{(nvs_pkg::OUT_DATA_W - IW - DW){1'b0}}, out_dist_r, out_idx_r};
  assign out_tuser  = out_stat_r;

endmodule

[design/nvs_point_mem.sv]
// ---------------------------------------------------------------------------
// nvs_point_mem: point table storage
// One write port and one read port with a registered read data output.
// ---------------------------------------------------------------------------
module nvs_point_mem #(
  parameter int unsigned DEPTH  = 1024,
  parameter int unsigned DATA_W = 42
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/nvs_sq_dist.sv]
// ---------------------------------------------------------------------------
// nvs_sq_dist: squared distance pipeline
// Three stages: absolute coordinate differences, squares, and their sum.
// ---------------------------------------------------------------------------
module nvs_sq_dist #(
  parameter int unsigned COORD_BITS = 14
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  nvs_pkg::tag_t             tag_in,
  input  logic [3*COORD_BITS-1:0]   point,
  input  logic [3*COORD_BITS-1:0]   query,
  output nvs_pkg::tag_t             tag_out,
  output logic [2*COORD_BITS+1:0]   sum_sq
);

  localparam int unsigned CB = COORD_BITS;

  logic [CB-1:0]     ad_r [3];
  logic [2*CB-1:0]   sq_r [3];
  logic [2*CB+1:0]   sum_r;
  nvs_pkg::tag_t     tag_r [3];
  logic [CB-1:0]     ad_nxt [3];

  always_comb begin
    logic signed [CB:0] a;
    logic signed [CB:0] b;
    logic signed [CB:0] d;
    logic [CB:0]        m;
    for (int k = 0; k < 3; k++) begin
      a = $signed({point[k*CB+CB-1], point[k*CB +: CB]});
      b = $signed({query[k*CB+CB-1], query[k*CB +: CB]});
      d = a - b;
      m = d[CB] ? (~d + 1'b1) : d;
      ad_nxt[k] = m[CB-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 3; k++) begin
      ad_r[k] <= ad_nxt[k];
      sq_r[k] <= ad_r[k] * ad_r[k];
    end
    sum_r <= (2*CB+2)'(sq_r[0]) + (2*CB+2)'(sq_r[1]) + (2*CB+2)'(sq_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < 3; k++) begin
        tag_r[k] <= '0;
      end
    end else begin
      tag_r[0] <= tag_in;
      tag_r[1] <= tag_r[0];
      tag_r[2] <= tag_r[1];
    end
  end

  assign tag_out = tag_r[2];
  assign sum_sq  = sum_r;

endmodule

[design/nvs_isqrt.sv]
// ---------------------------------------------------------------------------
// nvs_isqrt: pipelined integer square root
// Restoring square root that settles one result bit per stage.
// ---------------------------------------------------------------------------
module nvs_isqrt #(
  parameter int unsigned RAD_W = 30
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  nvs_pkg::tag_t         tag_in,
  input  logic [RAD_W-1:0]      radicand,
  output nvs_pkg::tag_t         tag_out,
  output logic [RAD_W/2-1:0]    root
);

  localparam int unsigned RW    = RAD_W / 2;
  localparam int unsigned REM_W = RW + 2;

  logic [REM_W-1:0]  rem_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [RAD_W-1:0]  rad_r  [RW];
  nvs_pkg::tag_t     tag_r  [RW];

  for (genvar i = 0; i < RW; i++) begin : g_stage
    logic [REM_W-1:0] rem_p;
    logic [RW-1:0]    root_p;
    logic [RAD_W-1:0] rad_p;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             ge;

    if (i == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign rad_p  = radicand;
    end else begin : g_next
      assign rem_p  = rem_r[i-1];
      assign root_p = root_r[i-1];
      assign rad_p  = rad_r[i-1];
    end

    assign rem_sh = {rem_p[REM_W-3:0], rad_p[RAD_W-1:RAD_W-2]};
    assign trial  = {root_p, 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      rem_r[i]  <= ge ? (rem_sh - trial) : rem_sh;
      root_r[i] <= {root_p[RW-2:0], ge};
      rad_r[i]  <= {rad_p[RAD_W-3:0], 2'b00};
    end

    if (i == 0) begin : g_tag_first
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tag_r[i] <= '0;
        end else begin
          tag_r[i] <= tag_in;
        end
      end
    end else begin : g_tag_next
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          tag_r[i] <= '0;
        end else begin
          tag_r[i] <= tag_r[i-1];
        end
      end
    end
  end

  assign tag_out = tag_r[RW-1];
  assign root    = root_r[RW-1];

endmodule

[test/tb_nearest_vertex_search.sv]
// ---------------------------------------------------------------------------
// tb_nearest_vertex_search: self-checking bench for the nearest vertex search
// Streams add and query transactions into the block and predicts every
// result from a private copy of the point table. Results are compared field
// by field, in order. A short directed part covers the empty table, the
// coordinate extremes, the largest distance and ties on floored distance.
// Random traffic follows, and a last part adds and queries without stalls.
// Both sides stall in random bursts. The receiver holds off once for a long
// stretch, and the sender once waits for all results.
// ---------------------------------------------------------------------------
module tb_nearest_vertex_search;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 1024;
  localparam int IDLE_LIMIT  = 6000;
  localparam int HOLD_AT     = 150;
  localparam int HOLD_CYCLES = 300;

  typedef logic signed [nvs_pkg::IN_COORD_W-1:0] coord_t;

  typedef struct {
    logic   op;
    coord_t x;
    coord_t y;
    coord_t z;
    int     gap;
    bit     drain;
    bit     calm;
  } point_op_t;

  typedef struct {
    logic [nvs_pkg::IDX_OUT_W-1:0]  index;
    logic [nvs_pkg::DIST_OUT_W-1:0] distance;
    logic [nvs_pkg::STAT_W-1:0]     status;
  } lookup_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [nvs_pkg::IN_DATA_W-1:0]  in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [nvs_pkg::OUT_DATA_W-1:0] out_tdata;
  logic [nvs_pkg::STAT_W-1:0]     out_tuser;
  logic                           calm = 1'b0;

  point_op_t      pending_ops[$];
  lookup_result_t expected_results[$];

  // Predictor state.
  longint stored_x[TABLE_DEPTH];
  longint stored_y[TABLE_DEPTH];
  longint stored_z[TABLE_DEPTH];
  int     stored_count = 0;

  // Driver state.
  point_op_t cur_op;
  bit        have_op = 0;
  int        gap_left = 0;
  int        sent_count = 0;
  int        results_seen = 0;

  int errors = 0;

  nearest_vertex_search u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic longint floor_root(longint v);
    longint r;
    r = longint'($sqrt(real'(v)));
    while (r > 0 && r * r > v) r--;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  function automatic lookup_result_t apply_point_op(point_op_t t);
    lookup_result_t res;
    longint         dx;
    longint         dy;
    longint         dz;
    longint         d;
    longint         best;
    res.index    = '0;
    res.distance = '0;
    res.status   = nvs_pkg::STAT_OK;
    if (t.op == nvs_pkg::OP_ADD) begin
      if (stored_count >= TABLE_DEPTH) begin
        res.status = nvs_pkg::STAT_FULL;
      end else begin
        stored_x[stored_count] = longint'(t.x);
        stored_y[stored_count] = longint'(t.y);
        stored_z[stored_count] = longint'(t.z);
        res.index = stored_count[nvs_pkg::IDX_OUT_W-1:0];
        stored_count++;
      end
    end else if (stored_count == 0) begin
      res.status = nvs_pkg::STAT_EMPTY;
    end else begin
      best = -1;
      for (int i = 0; i < stored_count; i++) begin
        dx = stored_x[i] - longint'(t.x);
        dy = stored_y[i] - longint'(t.y);
        dz = stored_z[i] - longint'(t.z);
        d = floor_root(dx * dx + dy * dy + dz * dz);
        if (best < 0 || d < best) begin
          best = d;
          res.index = i[nvs_pkg::IDX_OUT_W-1:0];
        end
      end
      res.distance = best[nvs_pkg::DIST_OUT_W-1:0];
    end
    return res;
  endfunction

  // Sender.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) results_seen++;
      if (in_tvalid && in_tready) begin
        expected_results.insert(expected_results.size(), apply_point_op(cur_op));
        sent_count++;
        have_op = 0;
      end
      if (!have_op && pending_ops.size() > 0) begin
        cur_op = pending_ops.pop_front();
        have_op = 1;
        gap_left = cur_op.gap;
      end
      if (have_op && gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (have_op && cur_op.drain && sent_count != results_seen) begin
        in_tvalid <= 1'b0;
      end else if (have_op) begin
        in_tvalid <= 1'b1;
        in_tdata  <= {{(nvs_pkg::IN_DATA_W - 3 * nvs_pkg::IN_COORD_W){1'b0}},
                      cur_op.z, cur_op.y, cur_op.x};
        in_tuser  <= cur_op.op;
        calm      <= cur_op.calm;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Receiver ready pattern.
  int  ready_seen = 0;
  int  stall_left = 0;
  int  hold_left = 0;
  bit  hold_done = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) ready_seen++;
      if (!hold_done && ready_seen == HOLD_AT) begin
        hold_done = 1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 10) - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: tdata=%h tuser=%h", out_tdata, out_tuser);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (out_tdata[nvs_pkg::IDX_OUT_W-1:0] !== want.index) begin
          $error("point_index: expected %0d, actual %0d", want.index,
                 out_tdata[nvs_pkg::IDX_OUT_W-1:0]);
          errors++;
        end
        if (out_tdata[nvs_pkg::IDX_OUT_W +: nvs_pkg::DIST_OUT_W] !== want.distance) begin
          $error("nearest_distance: expected %0d, actual %0d", want.distance,
                 out_tdata[nvs_pkg::IDX_OUT_W +: nvs_pkg::DIST_OUT_W]);
          errors++;
        end
        if (out_tuser !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_tuser);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("nearest_vertex_search test failed");
        $finish;
      end
    end
  end

  // Stimulus.
  coord_t added_x[$];
  coord_t added_y[$];
  coord_t added_z[$];
  bit     tail_calm = 0;

  task automatic queue_op(logic op, coord_t x, coord_t y, coord_t z, bit drain = 0);
    point_op_t t;
    t.op    = op;
    t.x     = x;
    t.y     = y;
    t.z     = z;
    t.drain = drain;
    t.calm  = tail_calm;
    t.gap   = 0;
    if (!tail_calm && $urandom_range(0, 3) == 0) t.gap = $urandom_range(1, 10);
    pending_ops.insert(pending_ops.size(), t);
    if (op == nvs_pkg::OP_ADD) begin
      added_x.insert(added_x.size(), x);
      added_y.insert(added_y.size(), y);
      added_z.insert(added_z.size(), z);
    end
  endtask

  function automatic coord_t random_coord(int mode);
    coord_t c;
    case (mode)
      0: c = coord_t'($urandom);
      1: c = coord_t'($urandom_range(0, 32) - 16);
      2: begin
        case ($urandom_range(0, 3))
          0: c = -14'sd8192;
          1: c = 14'sd8191;
          2: c = 14'sd0;
          default: c = -14'sd1;
        endcase
      end
      default: c = coord_t'($urandom_range(0, 400) - 200);
    endcase
    return c;
  endfunction

  initial begin
    int     mode;
    int     pick;
    logic   op;
    coord_t qx;
    coord_t qy;
    coord_t qz;

    // Directed part.
    queue_op(nvs_pkg::OP_QUERY, 14'sd8191, -14'sd8192, 14'sd0);
    queue_op(nvs_pkg::OP_ADD, -14'sd8192, -14'sd8192, -14'sd8192);
    queue_op(nvs_pkg::OP_QUERY, 14'sd8191, 14'sd8191, 14'sd8191);
    queue_op(nvs_pkg::OP_ADD, 14'sd8191, 14'sd8191, 14'sd8191);
    queue_op(nvs_pkg::OP_QUERY, 14'sd0, 14'sd0, 14'sd0);
    queue_op(nvs_pkg::OP_ADD, 14'sd8191, 14'sd8191, 14'sd8191);
    queue_op(nvs_pkg::OP_QUERY, 14'sd8191, 14'sd8191, 14'sd8191);
    queue_op(nvs_pkg::OP_ADD, 14'sd0, 14'sd3, 14'sd1);
    queue_op(nvs_pkg::OP_ADD, 14'sd3, 14'sd0, 14'sd0);
    queue_op(nvs_pkg::OP_QUERY, 14'sd0, 14'sd0, 14'sd0);
    queue_op(nvs_pkg::OP_ADD, 14'sh1555, 14'sh2aaa, 14'sh1555);
    queue_op(nvs_pkg::OP_ADD, 14'sh2aaa, 14'sh1555, 14'sh2aaa);
    queue_op(nvs_pkg::OP_QUERY, 14'sh1555, 14'sh2aaa, 14'sh1555);
    queue_op(nvs_pkg::OP_QUERY, 14'sh2aaa, 14'sh1555, 14'sh2aaa);
    queue_op(nvs_pkg::OP_QUERY, -14'sd8192, 14'sd8191, -14'sd8192);
    queue_op(nvs_pkg::OP_ADD, -14'sd1, -14'sd1, -14'sd1);
    queue_op(nvs_pkg::OP_QUERY, -14'sd1, -14'sd1, -14'sd2);

    // Random part: clustered coordinates make ties on the floored distance common.
    for (int n = 0; n < 540; n++) begin
      op = ($urandom_range(0, 99) < 55) ? nvs_pkg::OP_ADD : nvs_pkg::OP_QUERY;
      if (op == nvs_pkg::OP_QUERY && $urandom_range(0, 2) == 0) begin
        pick = $urandom_range(0, added_x.size() - 1);
        qx = coord_t'(added_x[pick] + $urandom_range(0, 6) - 3);
        qy = coord_t'(added_y[pick] + $urandom_range(0, 6) - 3);
        qz = coord_t'(added_z[pick] + $urandom_range(0, 6) - 3);
      end else begin
        mode = $urandom_range(0, 3);
        qx = random_coord(mode);
        qy = random_coord(mode);
        qz = random_coord(mode);
      end
      queue_op(op, qx, qy, qz, n == 300);
    end

    // Last part with no stalls.
    tail_calm = 1;
    pick = added_x.size() - 1;
    queue_op(nvs_pkg::OP_QUERY, added_x[pick], added_y[pick], added_z[pick]);
    for (int n = 0; n < 4; n++) begin
      queue_op(nvs_pkg::OP_ADD, random_coord(n % 3), random_coord(0), random_coord(2));
    end
    queue_op(nvs_pkg::OP_QUERY, 14'sd8191, 14'sd8191, 14'sd8191);
    queue_op(nvs_pkg::OP_QUERY, random_coord(0), random_coord(0), random_coord(0));
    queue_op(nvs_pkg::OP_ADD, -14'sd8192, 14'sd8191, 14'sd0);
    queue_op(nvs_pkg::OP_QUERY, random_coord(1), random_coord(1), random_coord(1));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk);
    while (!(pending_ops.size() == 0 && !have_op && sent_count == results_seen));
    repeat (50) @(posedge clk);

    if (expected_results.size() != 0) begin
      $error("results still expected at end: %0d", expected_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("nearest_vertex_search test passed");
    end else begin
      $display("nearest_vertex_search test failed");
    end
    $finish;
  end

endmodule

[nearest_vertex_search.f]
design/nvs_pkg.sv
design/nvs_point_mem.sv
design/nvs_sq_dist.sv
design/nvs_isqrt.sv
design/nearest_vertex_search.sv
test/tb_nearest_vertex_search.sv
